// File: design/gts_pkg.sv
// Package for the dual gripper timed sequencer.
// Holds the payload and config structs, phase and position codes and the phase_code helper.
// No dependencies.
`default_nettype none
package gts_pkg;

	localparam int NUM_ARMS_DEF = 2;
	localparam int DLY_W        = 7;
	localparam int PHASE_W      = 4;
	localparam int POS_W        = 2;
	localparam int CFG_IDX_W    = 3;

	// Phase codes as reported on the result channel
	localparam logic [PHASE_W-1:0] PC_IDLE        = 4'd0;
	localparam logic [PHASE_W-1:0] PC_WAIT        = 4'd1;
	localparam logic [PHASE_W-1:0] PC_DOWN_OPEN   = 4'd2;
	localparam logic [PHASE_W-1:0] PC_DOWN_CLOSED = 4'd3;
	localparam logic [PHASE_W-1:0] PC_UP_CLOSED   = 4'd4;
	localparam logic [PHASE_W-1:0] PC_UP_LOOSE    = 4'd5;
	localparam logic [PHASE_W-1:0] PC_FULL        = 4'd6;
	localparam logic [PHASE_W-1:0] PC_REGRIP      = 4'd7;
	localparam logic [PHASE_W-1:0] PC_DEP_CLOSED  = 4'd8;
	localparam logic [PHASE_W-1:0] PC_DEP_OPEN    = 4'd9;

	localparam logic [POS_W-1:0] ARM_TILTED  = 2'd0;
	localparam logic [POS_W-1:0] ARM_HIGH    = 2'd1;
	localparam logic [POS_W-1:0] ARM_LOW     = 2'd2;
	localparam logic [POS_W-1:0] GRIP_OPEN   = 2'd0;
	localparam logic [POS_W-1:0] GRIP_CLOSED = 2'd1;
	localparam logic [POS_W-1:0] GRIP_LOOSE  = 2'd2;

	localparam logic [DLY_W-1:0] RST_LONG_DLY  = 7'd100;
	localparam logic [DLY_W-1:0] RST_CATCH_DLY = 7'd10;

	typedef enum logic [9:0] {
		PH_IDLE        = 10'b00_0000_0001,
		PH_WAIT        = 10'b00_0000_0010,
		PH_DOWN_OPEN   = 10'b00_0000_0100,
		PH_DOWN_CLOSED = 10'b00_0000_1000,
		PH_UP_CLOSED   = 10'b00_0001_0000,
		PH_UP_LOOSE    = 10'b00_0010_0000,
		PH_FULL        = 10'b00_0100_0000,
		PH_REGRIP      = 10'b00_1000_0000,
		PH_DEP_CLOSED  = 10'b01_0000_0000,
		PH_DEP_OPEN    = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOSE   = 3'd0,
		CFG_LIFT    = 3'd1,
		CFG_DEPOSIT = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_CATCH   = 3'd4,
		CFG_SETTLE  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [DLY_W-1:0] close_delay;
		logic [DLY_W-1:0] lift_delay;
		logic [DLY_W-1:0] deposit_delay;
		logic [DLY_W-1:0] release_delay;
		logic [DLY_W-1:0] catch_delay;
		logic [DLY_W-1:0] settle_delay;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic left_request;
		logic right_request;
		logic left_piece;
		logic right_piece;
		logic force_load;
	} in_t;

	typedef struct packed {
		logic [PHASE_W-1:0] left_phase;
		logic [PHASE_W-1:0] right_phase;
		logic [POS_W-1:0]   left_arm_pos;
		logic [POS_W-1:0]   left_grip_pos;
		logic [POS_W-1:0]   right_arm_pos;
		logic [POS_W-1:0]   right_grip_pos;
		logic               left_sensor_flag;
	} out_t;

	// Per-arm status handed from a lane to the merge stage
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [POS_W-1:0]   arm_pos;
		logic [POS_W-1:0]   grip_pos;
	} lane_stat_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] c;
		c = PC_IDLE;
		unique case (ph)
			PH_IDLE:        c = PC_IDLE;
			PH_WAIT:        c = PC_WAIT;
			PH_DOWN_OPEN:   c = PC_DOWN_OPEN;
			PH_DOWN_CLOSED: c = PC_DOWN_CLOSED;
			PH_UP_CLOSED:   c = PC_UP_CLOSED;
			PH_UP_LOOSE:    c = PC_UP_LOOSE;
			PH_FULL:        c = PC_FULL;
			PH_REGRIP:      c = PC_REGRIP;
			PH_DEP_CLOSED:  c = PC_DEP_CLOSED;
			PH_DEP_OPEN:    c = PC_DEP_OPEN;
			default:        c = PC_IDLE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: design/gts_lane.sv
// One arm lane: delay timer, phase sequencer and servo position registers.
// Depends on gts_pkg. Updates its state on each accepted request.
`default_nettype none
module gts_lane
	import gts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       tick,
	input  wire logic       req,
	input  wire logic       piece,
	input  wire logic       force_load,
	input  wire cfg_t       cfg,
	output lane_stat_t      nxt
);

	phase_t            phase_q, ph1, ph_n;
	logic [DLY_W-1:0]  timer_q, t1, t_n;
	logic [POS_W-1:0]  arm_q, arm_n, grip_q, grip_n;

	always_comb begin
		t1 = (tick && timer_q != '0) ? timer_q - 1'b1 : timer_q;

		ph1 = phase_q;
		if (req) begin
			if (phase_q == PH_IDLE)
				ph1 = PH_WAIT;
			else if (phase_q == PH_FULL)
				ph1 = PH_REGRIP;
		end
		if (force_load)
			ph1 = PH_WAIT;

		ph_n   = ph1;
		t_n    = t1;
		arm_n  = arm_q;
		grip_n = grip_q;
		unique case (ph1)
			PH_IDLE: begin
				arm_n  = ARM_HIGH;
				grip_n = GRIP_OPEN;
				t_n    = cfg.catch_delay;
			end
			PH_WAIT: begin
				arm_n  = ARM_LOW;
				grip_n = GRIP_OPEN;
				ph_n   = PH_DOWN_OPEN;
			end
			PH_DOWN_OPEN: begin
				if (piece) begin
					if (t1 == '0) begin
						ph_n   = PH_DOWN_CLOSED;
						grip_n = GRIP_CLOSED;
						t_n    = cfg.close_delay;
					end
				end else begin
					t_n = cfg.catch_delay;
				end
			end
			PH_DOWN_CLOSED: begin
				if (t1 == '0) begin
					ph_n  = PH_UP_CLOSED;
					arm_n = ARM_HIGH;
					t_n   = cfg.lift_delay;
				end
			end
			PH_UP_CLOSED: begin
				if (t1 == '0) begin
					ph_n   = PH_UP_LOOSE;
					grip_n = GRIP_LOOSE;
					t_n    = cfg.settle_delay;
				end
			end
			PH_UP_LOOSE: begin
				if (t1 == '0) begin
					ph_n   = PH_FULL;
					grip_n = GRIP_CLOSED;
					t_n    = cfg.settle_delay;
				end
			end
			PH_FULL: begin
				// holds until a request or force_load moves it on
			end
			PH_REGRIP: begin
				if (t1 == '0) begin
					ph_n  = PH_DEP_CLOSED;
					arm_n = ARM_TILTED;
					t_n   = cfg.deposit_delay;
				end
			end
			PH_DEP_CLOSED: begin
				if (t1 == '0) begin
					ph_n   = PH_DEP_OPEN;
					grip_n = GRIP_OPEN;
					t_n    = cfg.release_delay;
				end
			end
			PH_DEP_OPEN: begin
				if (t1 == '0)
					ph_n = PH_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			arm_q   <= ARM_TILTED;
			grip_q  <= GRIP_OPEN;
		end else if (en) begin
			phase_q <= ph_n;
			timer_q <= t_n;
			arm_q   <= arm_n;
			grip_q  <= grip_n;
		end
	end

	assign nxt.phase    = phase_code(ph_n);
	assign nxt.arm_pos  = arm_n;
	assign nxt.grip_pos = grip_n;

endmodule
`default_nettype wire

// File: design/gts_merge.sv
// Merge stage: gathers the left and right lane status into one result.
// Depends on gts_pkg. Lanes beyond the second are stepped but not reported.
`default_nettype none
module gts_merge
	import gts_pkg::*;
#(
	parameter int NUM_ARMS = NUM_ARMS_DEF
) (
	input  wire lane_stat_t lane [NUM_ARMS],
	input  wire logic       left_piece,
	output out_t            res
);

	assign res.left_phase       = lane[0].phase;
	assign res.left_arm_pos     = lane[0].arm_pos;
	assign res.left_grip_pos    = lane[0].grip_pos;
	assign res.left_sensor_flag = left_piece;

	generate
		if (NUM_ARMS >= 2) begin : g_right
			assign res.right_phase    = lane[1].phase;
			assign res.right_arm_pos  = lane[1].arm_pos;
			assign res.right_grip_pos = lane[1].grip_pos;
		end else begin : g_no_right
			assign res.right_phase    = '0;
			assign res.right_arm_pos  = '0;
			assign res.right_grip_pos = '0;
		end
	endgenerate

endmodule
`default_nettype wire

// File: design/dual_gripper_timed_sequencer.sv
// Dual gripper timed sequencer, top level.
// Each request on the in channel is one pass of the arm control loop; every pass
// yields exactly one result on the out channel (phases, servo codes, left sensor).
// Channels: in (in_valid/in_ready/in_data), out (out_valid/out_ready/out_data),
// config writes (cfg_valid/cfg_ready/cfg_index/cfg_data); cfg_ready is always high,
// indexes past the last delay register are ignored.
// Results are registered in the output register, or in the skid register on a stall.
// Throughput: one request per cycle while in_ready is high; each arm lane updates its
// timer, phase and servo registers on each accepted request.
// A skid register behind the output lets one more request in while the receiver
// stalls; in_ready drops only when both output and skid are occupied.
// Reset: arms return to idle with timers zero, arm tilted and gripper open; delay
// registers return to 100 ticks (catch delay 10); no result is pending.
// Depends on gts_pkg, gts_lane, gts_merge.
`default_nettype none
module dual_gripper_timed_sequencer
	import gts_pkg::*;
#(
	parameter int NUM_ARMS = NUM_ARMS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_t                  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_t                      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DLY_W-1:0]     cfg_data
);

	cfg_t       cfg_q;
	lane_stat_t lane_nxt [NUM_ARMS];
	out_t       res, out_q, skid_q;
	logic       out_vld_q, skid_vld_q, acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_vld_q;
	assign acc       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_delay   <= RST_LONG_DLY;
			cfg_q.lift_delay    <= RST_LONG_DLY;
			cfg_q.deposit_delay <= RST_LONG_DLY;
			cfg_q.release_delay <= RST_LONG_DLY;
			cfg_q.catch_delay   <= RST_CATCH_DLY;
			cfg_q.settle_delay  <= RST_LONG_DLY;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CLOSE:   cfg_q.close_delay   <= cfg_data;
				CFG_LIFT:    cfg_q.lift_delay    <= cfg_data;
				CFG_DEPOSIT: cfg_q.deposit_delay <= cfg_data;
				CFG_RELEASE: cfg_q.release_delay <= cfg_data;
				CFG_CATCH:   cfg_q.catch_delay   <= cfg_data;
				CFG_SETTLE:  cfg_q.settle_delay  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	generate
		for (genvar i = 0; i < NUM_ARMS; i++) begin : g_lane
			logic req_i, piece_i;
			if (i == 0) begin : g_left
				assign req_i   = in_data.left_request;
				assign piece_i = in_data.left_piece;
			end else if (i == 1) begin : g_right
				assign req_i   = in_data.right_request;
				assign piece_i = in_data.right_piece;
			end else begin : g_extra
				assign req_i   = 1'b0;
				assign piece_i = 1'b0;
			end

			gts_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (acc),
				.tick       (in_data.tick),
				.req        (req_i),
				.piece      (piece_i),
				.force_load (in_data.force_load),
				.cfg        (cfg_q),
				.nxt        (lane_nxt[i])
			);
		end
	endgenerate

	gts_merge #(
		.NUM_ARMS (NUM_ARMS)
	) u_merge (
		.lane       (lane_nxt),
		.left_piece (in_data.left_piece),
		.res        (res)
	);

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= acc;
			end
		end else if (acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q)
				out_q <= skid_q;
			else if (acc)
				out_q <= res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// File: design/gts_checker.sv
// Port-level checker for the dual gripper timed sequencer, with its bind.
// Depends on gts_pkg and the top level's ports.
`default_nettype none
module gts_checker
	import gts_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	// a request taken with the output empty shows up the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("result missing one cycle after request");

	// wait-for-piece always steps straight on to down-open in the same pass
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.left_phase != PC_WAIT && out_data.right_phase != PC_WAIT)
		else $error("wait phase reported");

	// down-open means arm low with gripper open
	a_down_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.left_phase == PC_DOWN_OPEN |->
			out_data.left_arm_pos == ARM_LOW && out_data.left_grip_pos == GRIP_OPEN)
		else $error("down-open with wrong servo codes");

endmodule

bind dual_gripper_timed_sequencer gts_checker u_gts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
